// ===== src/stxp_pkg.sv =====
`default_nettype none
package stxp_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLE_IS_SLAVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE      = 3'd5;

    localparam logic       RESET_ROLE_IS_SLAVE = 1'b0;
    localparam logic [7:0] RESET_START_MARKER  = 8'hAA;
    localparam logic [7:0] RESET_END_MARKER    = 8'h55;
    localparam logic [7:0] RESET_WRITE_CODE    = 8'h01;
    localparam logic [7:0] RESET_READ_CODE     = 8'h02;
    localparam logic [7:0] RESET_ACK_CODE      = 8'h03;

    typedef struct packed {
        logic       role_is_slave;
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] write_code;
        logic [7:0] read_code;
        logic [7:0] ack_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  frame_command;
        logic [7:0]  frame_var_id;
        logic        frame_has_value;
        logic [15:0] frame_value;
    } t_result;

endpackage
`default_nettype wire

// ===== src/stxp_cfg_regs.sv =====
`default_nettype none
module stxp_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [stxp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [stxp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output stxp_pkg::t_cfg                       o_cfg
);
    import stxp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.role_is_slave <= RESET_ROLE_IS_SLAVE;
            r_cfg.start_marker  <= RESET_START_MARKER;
            r_cfg.end_marker    <= RESET_END_MARKER;
            r_cfg.write_code    <= RESET_WRITE_CODE;
            r_cfg.read_code     <= RESET_READ_CODE;
            r_cfg.ack_code      <= RESET_ACK_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROLE_IS_SLAVE: r_cfg.role_is_slave <= i_cfg_data[0];
                CFG_START_MARKER:  r_cfg.start_marker  <= i_cfg_data;
                CFG_END_MARKER:    r_cfg.end_marker    <= i_cfg_data;
                CFG_WRITE_CODE:    r_cfg.write_code    <= i_cfg_data;
                CFG_READ_CODE:     r_cfg.read_code     <= i_cfg_data;
                CFG_ACK_CODE:      r_cfg.ack_code      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== src/stxp_parser.sv =====
`default_nettype none
module stxp_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_rx_byte,
    input  wire stxp_pkg::t_cfg i_cfg,
    output logic            o_res_valid,
    output stxp_pkg::t_result o_res
);
    import stxp_pkg::*;

    localparam logic [2:0] POS_IDLE    = 3'd0;
    localparam logic [2:0] POS_COMMAND = 3'd1;
    localparam logic [2:0] POS_VAR_ID  = 3'd2;
    localparam logic [2:0] POS_THIRD   = 3'd3;
    localparam logic [2:0] POS_HIGH    = 3'd4;
    localparam logic [2:0] POS_LAST    = 3'd5;

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic       r_long;
    logic       n_long;
    logic [7:0] r_command;
    logic [7:0] r_var_id;
    logic [7:0] r_value_low;
    logic [7:0] r_value_high;
    logic       is_final;
    logic       known_cmd;
    logic       long_cmd;

    always_comb begin
        known_cmd = 1'b1;
        long_cmd  = 1'b1;
        if (i_rx_byte == i_cfg.write_code || i_rx_byte == i_cfg.ack_code) begin
            long_cmd = 1'b1;
        end else if (i_rx_byte == i_cfg.read_code) begin
            long_cmd = !i_cfg.role_is_slave;
        end else begin
            known_cmd = 1'b0;
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_long   = r_long;
        is_final = 1'b0;
        unique case (r_pos)
            POS_IDLE: begin
                if (i_rx_byte == i_cfg.start_marker) begin
                    n_pos = POS_COMMAND;
                end
            end
            POS_COMMAND: begin
                n_long = long_cmd;
                n_pos  = known_cmd ? POS_VAR_ID : POS_IDLE;
            end
            POS_VAR_ID: begin
                n_pos = POS_THIRD;
            end
            POS_THIRD: begin
                if (r_long) begin
                    n_pos = POS_HIGH;
                end else begin
                    is_final = 1'b1;
                    n_pos    = POS_IDLE;
                end
            end
            POS_HIGH: begin
                n_pos = POS_LAST;
            end
            POS_LAST: begin
                is_final = 1'b1;
                n_pos    = POS_IDLE;
            end
            default: begin
                n_pos = POS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_IDLE;
            r_long <= 1'b0;
        end else if (i_take) begin
            r_pos  <= n_pos;
            r_long <= n_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            if (r_pos == POS_COMMAND) begin
                r_command <= i_rx_byte;
            end
            if (r_pos == POS_VAR_ID) begin
                r_var_id <= i_rx_byte;
            end
            if (r_pos == POS_THIRD) begin
                r_value_low <= i_rx_byte;
            end
            if (r_pos == POS_HIGH) begin
                r_value_high <= i_rx_byte;
            end
        end
    end

    assign o_res_valid = i_take && is_final && (i_rx_byte == i_cfg.end_marker);

    always_comb begin
        o_res.frame_command   = r_command;
        o_res.frame_var_id    = r_var_id;
        o_res.frame_has_value = r_long;
        o_res.frame_value     = r_long ? {r_value_high, r_value_low} : 16'd0;
    end

endmodule
`default_nettype wire

// ===== src/stxp_out_stage.sv =====
`default_nettype none
module stxp_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire stxp_pkg::t_result i_res,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_stall,
    output stxp_pkg::t_result  o_res
);
    import stxp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end else if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
`default_nettype wire

// ===== src/stx_etx_command_frame_parser_core.sv =====
// A result is registered in the output register, or in the skid register behind a stalled one.
// Throughput: one byte item per cycle while o_stall is low; o_stall rises only while a second
// result waits in the skid register behind a stalled output register.
// Reset (synchronous, active low): the parser returns to idle, both output registers
// empty, and the configuration registers take their default values.
`default_nettype none
module stx_etx_command_frame_parser_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [7:0]                           o_frame_command,
    output logic [7:0]                           o_frame_var_id,
    output logic                                 o_frame_has_value,
    output logic [15:0]                          o_frame_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [stxp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [stxp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import stxp_pkg::*;

    t_cfg    cfg;
    t_result parse_res;
    t_result out_res;
    logic    parse_valid;
    logic    take;
    logic    full;

    assign o_stall = full;
    assign take    = i_valid && !full;

    stxp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    stxp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (parse_valid),
        .o_res       (parse_res)
    );

    stxp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (parse_valid),
        .i_res   (parse_res),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_frame_command   = out_res.frame_command;
    assign o_frame_var_id    = out_res.frame_var_id;
    assign o_frame_has_value = out_res.frame_has_value;
    assign o_frame_value     = out_res.frame_value;

endmodule
`default_nettype wire
